// ----- hw/rtl/tqsb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tqsb_pkg;

  localparam int DEPTH_DEF = 128;
  localparam int DATA_W    = 32;

  typedef enum logic [1:0] {
    ACT_PUSH_ONE = 2'd0,
    ACT_PUSH_TWO = 2'd1,
    ACT_POP_ONE  = 2'd2,
    ACT_POP_TWO  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture the incoming transaction
    logic exec;     // decide, access the buffer, move pointers
    logic present;  // drive the result for one cycle
  } cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tqsb_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tqsb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  output tqsb_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy        = (state_r != S_IDLE);
  assign cmd.load    = (state_r == S_IDLE) && start;
  assign cmd.exec    = (state_r == S_EXEC);
  assign cmd.present = (state_r == S_DONE);

endmodule

`default_nettype wire

// ----- hw/rtl/tqsb_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tqsb_dp #(
  parameter int DEPTH = tqsb_pkg::DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire tqsb_pkg::cmd_t                      cmd,
  input  wire logic [1:0]                          in_action,
  input  wire logic signed [tqsb_pkg::DATA_W-1:0]  in_value,
  output logic                                     out_valid,
  output logic signed [tqsb_pkg::DATA_W-1:0]       out_data,
  output logic [1:0]                               out_status,
  output logic                                     out_one_empty,
  output logic                                     out_two_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_TOP = PW'(DEPTH);
  localparam logic [AW-1:0] IDX_TOP = AW'(DEPTH - 1);

  tqsb_pkg::action_t act_r;
  logic [tqsb_pkg::DATA_W-1:0] val_r;
  tqsb_pkg::status_t st_r, st_nxt;
  logic [PW-1:0] t1_r, t1_nxt, t2_r, t2_nxt, t2_dec;
  logic [AW-1:0] h1_r, h1_nxt, h2_r, h2_nxt;
  logic [AW-1:0] waddr, raddr;
  logic          we;
  logic [tqsb_pkg::DATA_W-1:0] rd_r;
  logic [tqsb_pkg::DATA_W-1:0] mem [DEPTH];
  logic full, e1, e2;

  // t1: next free slot of queue one (tail+1); t2: tail of queue two
  assign full   = (t1_r == t2_r);
  assign e1     = (t1_r == '0);
  assign e2     = (t2_r == PTR_TOP);
  assign t2_dec = t2_r - PW'(1);

  always_comb begin
    st_nxt = tqsb_pkg::ST_OK;
    t1_nxt = t1_r;
    t2_nxt = t2_r;
    h1_nxt = h1_r;
    h2_nxt = h2_r;
    we     = 1'b0;
    waddr  = t1_r[AW-1:0];
    raddr  = h1_r;
    case (act_r)
      tqsb_pkg::ACT_PUSH_ONE: begin
        if (full) begin
          st_nxt = tqsb_pkg::ST_FULL;
        end else begin
          we     = 1'b1;
          waddr  = t1_r[AW-1:0];
          t1_nxt = t1_r + PW'(1);
        end
      end
      tqsb_pkg::ACT_PUSH_TWO: begin
        if (full) begin
          st_nxt = tqsb_pkg::ST_FULL;
        end else begin
          we     = 1'b1;
          waddr  = t2_dec[AW-1:0];
          t2_nxt = t2_dec;
        end
      end
      tqsb_pkg::ACT_POP_ONE: begin
        raddr = h1_r;
        if (e1) begin
          st_nxt = tqsb_pkg::ST_EMPTY;
        end else if (PW'(h1_r) + PW'(1) == t1_r) begin
          h1_nxt = '0;
          t1_nxt = '0;
        end else begin
          h1_nxt = h1_r + AW'(1);
        end
      end
      tqsb_pkg::ACT_POP_TWO: begin
        raddr = h2_r;
        if (e2) begin
          st_nxt = tqsb_pkg::ST_EMPTY;
        end else if (PW'(h2_r) == t2_r) begin
          h2_nxt = IDX_TOP;
          t2_nxt = PTR_TOP;
        end else begin
          h2_nxt = h2_r - AW'(1);
        end
      end
      default: st_nxt = tqsb_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= tqsb_pkg::action_t'(in_action);
      val_r <= in_value;
    end
    if (cmd.exec) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && we) begin
      mem[waddr] <= val_r;
    end
    if (cmd.exec) begin
      rd_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r <= '0;
      h1_r <= '0;
      t2_r <= PTR_TOP;
      h2_r <= IDX_TOP;
    end else if (cmd.exec) begin
      t1_r <= t1_nxt;
      h1_r <= h1_nxt;
      t2_r <= t2_nxt;
      h2_r <= h2_nxt;
    end
  end

  assign out_valid     = cmd.present;
  assign out_status    = st_r;
  assign out_one_empty = e1;
  assign out_two_empty = e2;

  always_comb begin
    if (st_r == tqsb_pkg::ST_EMPTY) begin
      out_data = '1;
    end else if (act_r == tqsb_pkg::ACT_POP_ONE || act_r == tqsb_pkg::ACT_POP_TWO) begin
      out_data = rd_r;
    end else begin
      out_data = '0;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    t1_r <= t2_r)
    else $error("queue one tail passed queue two tail");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && we |-> !full)
    else $error("buffer written while full");

  a_refused_stable: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.exec) && st_r != tqsb_pkg::ST_OK |-> $stable(t1_r) && $stable(t2_r))
    else $error("pointers moved on a refused transaction");

  a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !e1 |-> PW'(h1_r) < t1_r)
    else $error("queue one head outside its entries");

endmodule

`default_nettype wire

// ----- hw/rtl/two_queues_shared_buffer_top.sv -----
// Channel  Ports                                   Handshake
// input    in_action[1:0], in_value[31:0]          start high and busy low
// result   out_data[31:0], out_status[1:0],        out_valid, one cycle, no stall
//          out_one_empty, out_two_empty
//
// From start to result, a transaction goes through capture, one buffer access
// with pointer update, then the result is shown (registered read data on a pop).
// busy stays high from the capture edge through the access and the result;
// start is taken again on the cycle after out_valid is high.
// rst_n is synchronous, active low; both queues come out of reset empty.
// The buffer itself is not cleared. The result receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module two_queues_shared_buffer_top #(
  parameter int DEPTH = tqsb_pkg::DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [1:0]                          in_action,
  input  wire logic signed [tqsb_pkg::DATA_W-1:0]  in_value,
  output logic                                     out_valid,
  output logic signed [tqsb_pkg::DATA_W-1:0]       out_data,
  output logic [1:0]                               out_status,
  output logic                                     out_one_empty,
  output logic                                     out_two_empty
);

  tqsb_pkg::cmd_t cmd;

  tqsb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  tqsb_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_action     (in_action),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_data      (out_data),
    .out_status    (out_status),
    .out_one_empty (out_one_empty),
    .out_two_empty (out_two_empty)
  );

endmodule

`default_nettype wire
